FILE: sv/plhs_pkg.sv
// Shared types, constants and index helpers for the playlist / history block.
// No dependencies; imported by every other file of the block but plhs_ram.
package plhs_pkg;

  localparam int LIST_DEPTH    = 16;
  localparam int HISTORY_DEPTH = 16;

  localparam int SONG_W = 16;
  localparam int POS_W  = 8;
  localparam int CMD_W  = 3;
  localparam int CNT_W  = 5;   // width of the count fields on the result bus

  localparam int LA_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LC_W = $clog2(LIST_DEPTH + 1);
  localparam int HA_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HC_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = ((LC_W > POS_W) ? LC_W : POS_W) + 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_PLAY   = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_UNDO   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_POS    = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_HIST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_SHIFT,
    S_UNDO,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [LA_W-1:0]   waddr;
    logic [SONG_W-1:0] wdata;
    logic [LA_W-1:0]   raddr;
  } lram_req_t;

  typedef struct packed {
    logic              we;
    logic [HA_W-1:0]   waddr;
    logic [SONG_W-1:0] wdata;
    logic [HA_W-1:0]   raddr;
  } hram_req_t;

  typedef struct packed {
    status_t           status;
    logic [SONG_W-1:0] moved_song;
    logic [CNT_W-1:0]  playlist_count;
    logic [CNT_W-1:0]  history_count;
  } res_t;

  // ring index: (base + off) mod LIST_DEPTH, both operands below the depth
  function automatic logic [LA_W-1:0] list_phys(input logic [LA_W-1:0] base,
                                                input logic [LA_W-1:0] off);
    logic [LA_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (LA_W+1)'(LIST_DEPTH)) begin
      sum = sum - (LA_W+1)'(LIST_DEPTH);
    end
    return sum[LA_W-1:0];
  endfunction

  function automatic logic [HA_W-1:0] hist_phys(input logic [HA_W-1:0] base,
                                                input logic [HA_W-1:0] off);
    logic [HA_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (HA_W+1)'(HISTORY_DEPTH)) begin
      sum = sum - (HA_W+1)'(HISTORY_DEPTH);
    end
    return sum[HA_W-1:0];
  endfunction

endpackage

FILE: sv/plhs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module plhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/plhs_ctrl.sv
// Command sequencer: ring pointers, sizes and read-modify-write of both stores.
// Depends on plhs_pkg; drives the two plhs_ram instances in the top level.
module plhs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  plhs_pkg::cmd_t              cmd,
  input  logic [plhs_pkg::SONG_W-1:0] song_id,
  input  logic [plhs_pkg::POS_W-1:0]  position,
  output plhs_pkg::lram_req_t         lreq,
  input  logic [plhs_pkg::SONG_W-1:0] l_rdata,
  output plhs_pkg::hram_req_t         hreq,
  input  logic [plhs_pkg::SONG_W-1:0] h_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output plhs_pkg::res_t              res
);
  import plhs_pkg::*;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  status_t           status_r, status_nxt;
  logic [SONG_W-1:0] moved_r, moved_nxt;
  logic [LA_W-1:0]   head_r, head_nxt;
  logic [LC_W-1:0]   lsize_r, lsize_nxt;
  logic [HA_W-1:0]   hbase_r, hbase_nxt;
  logic [HC_W-1:0]   hsize_r, hsize_nxt;
  logic [LA_W-1:0]   k_r, k_nxt;

  logic [LA_W-1:0]   head_dec;
  logic [LA_W-1:0]   idx;
  logic [LC_W:0]     k_p1, k_p2;
  logic              finish;
  logic [SONG_W-1:0] moved_v;

  assign head_dec = (head_r == '0) ? LA_W'(LIST_DEPTH - 1) : head_r - 1'b1;
  assign idx      = LA_W'(position - 1'b1);
  assign k_p1     = (LC_W+1)'(k_r) + 1'b1;
  assign k_p2     = (LC_W+1)'(k_r) + 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      lsize_r <= '0;
      hbase_r <= '0;
      hsize_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      lsize_r <= lsize_nxt;
      hbase_r <= hbase_nxt;
      hsize_r <= hsize_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    moved_r  <= moved_nxt;
    k_r      <= k_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    moved_nxt  = moved_r;
    head_nxt   = head_r;
    lsize_nxt  = lsize_r;
    hbase_nxt  = hbase_r;
    hsize_nxt  = hsize_r;
    k_nxt      = k_r;
    lreq       = '0;
    hreq       = '0;
    finish     = 1'b0;
    moved_v    = moved_r;
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt    = cmd;
          status_nxt = ST_OK;
          moved_nxt  = '0;
          state_nxt  = S_RESP;
          case (cmd)
            CMD_ADD: begin
              if (lsize_r >= LC_W'(LIST_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt   = head_dec;
                lreq.we    = 1'b1;
                lreq.waddr = head_dec;
                lreq.wdata = song_id;
                lsize_nxt  = lsize_r + 1'b1;
              end
            end
            CMD_PLAY, CMD_REMOVE: begin
              if (lsize_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (position == '0 || CMP_W'(position) > CMP_W'(lsize_r)) begin
                status_nxt = ST_BAD_POS;
              end else begin
                lreq.raddr = list_phys(head_r, idx);
                k_nxt      = idx;
                state_nxt  = S_TAKE;
              end
            end
            CMD_CLEAR: begin
              lsize_nxt = '0;
            end
            CMD_UNDO: begin
              if (hsize_r == '0) begin
                status_nxt = ST_HIST_EMPTY;
              end else if (lsize_r >= LC_W'(LIST_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                hreq.raddr = hist_phys(hbase_r, HA_W'(hsize_r - 1'b1));
                state_nxt  = S_UNDO;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // taken entry arrives; start pulling the tail down by one
      S_TAKE: begin
        moved_nxt = l_rdata;
        moved_v   = l_rdata;
        if (k_p1 < (LC_W+1)'(lsize_r)) begin
          lreq.raddr = list_phys(head_r, LA_W'(k_p1));
          state_nxt  = S_SHIFT;
        end else begin
          finish = 1'b1;
        end
      end

      // read k+2 while writing k with the data of k+1
      S_SHIFT: begin
        lreq.we    = 1'b1;
        lreq.waddr = list_phys(head_r, k_r);
        lreq.wdata = l_rdata;
        k_nxt      = LA_W'(k_p1);
        if (k_p2 < (LC_W+1)'(lsize_r)) begin
          lreq.raddr = list_phys(head_r, LA_W'(k_p2));
        end else begin
          finish = 1'b1;
        end
      end

      S_UNDO: begin
        moved_nxt  = h_rdata;
        hsize_nxt  = hsize_r - 1'b1;
        head_nxt   = head_dec;
        lreq.we    = 1'b1;
        lreq.waddr = head_dec;
        lreq.wdata = h_rdata;
        lsize_nxt  = lsize_r + 1'b1;
        state_nxt  = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of a take: shrink the list, push onto history for play
    if (finish) begin
      lsize_nxt = lsize_r - 1'b1;
      state_nxt = S_RESP;
      if (cmd_r == CMD_PLAY) begin
        hreq.we    = 1'b1;
        hreq.wdata = moved_v;
        if (hsize_r >= HC_W'(HISTORY_DEPTH)) begin
          // full: overwrite the oldest slot and advance the base
          hreq.waddr = hbase_r;
          hbase_nxt  = (hbase_r == HA_W'(HISTORY_DEPTH - 1)) ? '0 : hbase_r + 1'b1;
        end else begin
          hreq.waddr = hist_phys(hbase_r, hsize_r[HA_W-1:0]);
          hsize_nxt  = hsize_r + 1'b1;
        end
      end
    end
  end

  assign res.status         = status_r;
  assign res.moved_song     = moved_r;
  assign res.playlist_count = CNT_W'(lsize_r);
  assign res.history_count  = CNT_W'(hsize_r);

endmodule

FILE: sv/playlist_with_history_stack.sv
// Playlist with history stack: play/remove read the taken entry, then shift the
// tail (one entry per cycle through the list RAM's single read port); one command
// in flight: the next one is taken only once the last result has moved into the
// output register, where a finished word waits.
// rst_n is synchronous, active low: clears both counts and ring pointers; the
// RAM contents are not cleared and are never read before being written.
module playlist_with_history_stack (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [plhs_pkg::IN_DATA_W-1:0]  in_tdata,  // [15:0] song_id, [23:16] position
  input  logic [plhs_pkg::CMD_W-1:0]      in_tuser,  // [2:0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [plhs_pkg::OUT_DATA_W-1:0] out_tdata  // [2:0] status, [18:3] moved_song,
                                                     // [23:19] playlist_count,
                                                     // [28:24] history_count
);
  import plhs_pkg::*;

  lram_req_t         lreq;
  hram_req_t         hreq;
  logic [SONG_W-1:0] l_rdata;
  logic [SONG_W-1:0] h_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  logic              out_valid_r;
  res_t              out_res_r;

  // playlist ring: entry head is position 1
  plhs_ram #(.WIDTH(SONG_W), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk   (clk),
    .we    (lreq.we),
    .waddr (lreq.waddr),
    .wdata (lreq.wdata),
    .raddr (lreq.raddr),
    .rdata (l_rdata)
  );

  // history ring: base is the oldest entry, base + size - 1 the top
  plhs_ram #(.WIDTH(SONG_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hreq.we),
    .waddr (hreq.waddr),
    .wdata (hreq.wdata),
    .raddr (hreq.raddr),
    .rdata (h_rdata)
  );

  plhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd_t'(in_tuser)),
    .song_id   (in_tdata[SONG_W-1:0]),
    .position  (in_tdata[SONG_W +: POS_W]),
    .lreq      (lreq),
    .l_rdata   (l_rdata),
    .hreq      (hreq),
    .h_rdata   (h_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output word register; a new word loads when the slot is empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.history_count,
                       out_res_r.playlist_count,
                       out_res_r.moved_song,
                       out_res_r.status};

endmodule

FILE: sv/plhs_checker.sv
// Port-level checks for playlist_with_history_stack, bound to the top level.
// Depends on plhs_pkg for widths.
module plhs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [plhs_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [plhs_pkg::CMD_W-1:0]      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [plhs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import plhs_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one command at a time: no accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in flight");

  // counts never exceed the store depths
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:19] <= CNT_W'(LIST_DEPTH)) &&
                   (out_tdata[28:24] <= CNT_W'(HISTORY_DEPTH)))
    else $error("count beyond store depth");

  // any error status carries no song
  a_err_no_song: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != ST_OK) |-> (out_tdata[18:3] == '0))
    else $error("error result carries a song");

endmodule

bind playlist_with_history_stack plhs_checker u_plhs_checker (.*);

FILE: tb/playlist_checker.sv
// Watches both stream channels of the playlist / history block, predicts each reply
// word from its own copy of the playlist and history, and compares field by field.
// Depends on plhs_pkg for widths, depths, command and status codes.
module playlist_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [plhs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [plhs_pkg::CMD_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [plhs_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              errors,
  output int                              pending,
  output int                              songs_listed
);
  import plhs_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [SONG_W-1:0] song;
    logic [CNT_W-1:0]  list_cnt;
    logic [CNT_W-1:0]  hist_cnt;
  } play_reply_t;

  logic [SONG_W-1:0] tracks [LIST_DEPTH];
  logic [SONG_W-1:0] played [HISTORY_DEPTH];
  int                list_n;
  int                hist_n;
  play_reply_t       replies_due [$];

  function automatic void front_insert(logic [SONG_W-1:0] song);
    for (int i = list_n; i > 0; i--) tracks[i] = tracks[i-1];
    tracks[0] = song;
    list_n++;
  endfunction

  // Apply one command to the shadow playlist and return the reply it should produce.
  function automatic play_reply_t next_reply(logic [CMD_W-1:0] cmd,
                                             logic [SONG_W-1:0] song,
                                             logic [POS_W-1:0] pos);
    play_reply_t r;
    r.status = ST_OK;
    r.song   = '0;
    case (cmd)
      CMD_ADD: begin
        if (list_n >= LIST_DEPTH) r.status = ST_FULL;
        else front_insert(song);
      end
      CMD_PLAY, CMD_REMOVE: begin
        if (list_n == 0) begin
          r.status = ST_EMPTY;
        end else if (pos == 0 || pos > list_n) begin
          r.status = ST_BAD_POS;
        end else begin
          r.song = tracks[pos-1];
          for (int i = pos - 1; i + 1 < list_n; i++) tracks[i] = tracks[i+1];
          list_n--;
          if (cmd == CMD_PLAY) begin
            // full history: oldest entry falls off the bottom
            if (hist_n >= HISTORY_DEPTH) begin
              for (int i = 0; i + 1 < HISTORY_DEPTH; i++) played[i] = played[i+1];
              hist_n = HISTORY_DEPTH - 1;
            end
            played[hist_n] = r.song;
            hist_n++;
          end
        end
      end
      CMD_CLEAR: list_n = 0;
      CMD_UNDO: begin
        if (hist_n == 0) begin
          r.status = ST_HIST_EMPTY;
        end else if (list_n >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          hist_n--;
          r.song = played[hist_n];
          front_insert(r.song);
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    r.list_cnt = CNT_W'(list_n);
    r.hist_cnt = CNT_W'(hist_n);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    play_reply_t want;
    play_reply_t got;
    if (!rst_n) begin
      list_n = 0;
      hist_n = 0;
      errors = 0;
      replies_due.delete();
    end else begin
      // retire first: a reply can never belong to a word accepted on the same edge
      if (out_tvalid && out_tready) begin
        got.status   = status_t'(out_tdata[2:0]);
        got.song     = out_tdata[18:3];
        got.list_cnt = out_tdata[23:19];
        got.hist_cnt = out_tdata[28:24];
        if (replies_due.size() == 0) begin
          $error("reply word %h with nothing outstanding", out_tdata);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, got.status);
          check_field("moved_song", want.song, got.song);
          check_field("playlist_count", want.list_cnt, got.list_cnt);
          check_field("history_count", want.hist_cnt, got.hist_cnt);
        end
      end
      if (in_tvalid && in_tready)
        replies_due.push_back(next_reply(in_tuser, in_tdata[15:0], in_tdata[23:16]));
    end
    pending      = replies_due.size();
    songs_listed = list_n;
  end

endmodule

FILE: tb/tb_playlist_with_history_stack.sv
// Top of the playlist / history testbench: clock, reset, command stimulus, reply
// back-pressure and the verdict. Depends on plhs_pkg, playlist_checker and the block.
module tb_playlist_with_history_stack;
  import plhs_pkg::*;

  localparam int RANDOM_WORDS = 700;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int TAIL_CYCLES  = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [15:0] song_id, [23:16] position
  logic [CMD_W-1:0]      in_tuser = '0;   // [2:0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [2:0] status, [18:3] moved_song,
                                          // [23:19] playlist_count, [28:24] history_count
  int                    errors;
  int                    pending;
  int                    songs_listed;
  int                    cycles = 0;

  // receiver stall pattern: mode and its remaining length
  int                    rx_mode = 0;
  int                    rx_left = 0;

  always #1 clk = ~clk;

  playlist_with_history_stack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  playlist_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .errors       (errors),
    .pending      (pending),
    .songs_listed (songs_listed)
  );

  // Watchdog: a hung handshake or a lost reply word ends up here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reply side: runs of always-ready, light stalls and heavy stalls, each of
  // random length, so stalls land on every stage of a command.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Present one command word; called on a falling edge, returns on the falling
  // edge after the word was taken. tvalid stays high for a back-to-back word.
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [SONG_W-1:0] song,
                           logic [POS_W-1:0] pos);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pos, song};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold off until every reply word has come back.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Command mix per mode: 0 balanced, 1 fill the playlist, 2 play it down.
  // Undo stays common everywhere so the history both fills and empties.
  function automatic logic [CMD_W-1:0] pick_command(int mode);
    int r;
    int t_add;
    int t_play;
    int t_rem;
    int t_undo;
    int t_clr;
    r = $urandom_range(0, 99);
    case (mode)
      1:       begin t_add = 60; t_play = 75; t_rem = 80; t_undo = 95; t_clr = 96; end
      2:       begin t_add = 20; t_play = 70; t_rem = 85; t_undo = 95; t_clr = 96; end
      default: begin t_add = 30; t_play = 55; t_rem = 70; t_undo = 90; t_clr = 93; end
    endcase
    if (r < t_add)  return CMD_ADD;
    if (r < t_play) return CMD_PLAY;
    if (r < t_rem)  return CMD_REMOVE;
    if (r < t_undo) return CMD_UNDO;
    if (r < t_clr)  return CMD_CLEAR;
    // noise: one of the unused codes
    return CMD_W'($urandom_range(CMD_UNDO + 1, 2**CMD_W - 1));
  endfunction

  initial begin
    int                sent;
    int                mode;
    int                seg_len;
    int                burst_left;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty-list and empty-history errors, extreme ids,
    // bad positions at both ends, every command, the unused codes.
    send_word(CMD_UNDO,   16'h1234, 8'd0);    // history empty
    send_word(CMD_PLAY,   16'h0000, 8'd1);    // playlist empty, valid-looking position
    send_word(CMD_REMOVE, 16'h0000, 8'd0);    // empty wins over the bad position
    send_word(CMD_ADD,    16'hFFFF, 8'd255);
    send_word(CMD_ADD,    16'h0000, 8'd0);
    send_word(CMD_ADD,    16'hA5A5, 8'd3);
    send_word(CMD_PLAY,   16'h0000, 8'd0);    // position zero
    send_word(CMD_PLAY,   16'hFFFF, 8'd255);  // far past the end
    send_word(CMD_REMOVE, 16'h0000, 8'd4);    // one past the end
    send_word(CMD_PLAY,   16'h0000, 8'd3);    // last entry
    send_word(CMD_PLAY,   16'h0000, 8'd1);    // front entry
    send_word(CMD_UNDO,   16'h0000, 8'd0);
    send_word(CMD_REMOVE, 16'h0000, 8'd2);
    for (int c = CMD_UNDO + 1; c < 2**CMD_W; c++)
      send_word(CMD_W'(c), 16'($urandom), 8'($urandom));
    send_word(CMD_CLEAR,  16'hFFFF, 8'd255);
    send_word(CMD_UNDO,   16'h0000, 8'd0);    // history survives a clear
    send_word(CMD_ADD,    16'h5A5A, 8'd0);
    send_word(CMD_PLAY,   16'h0000, 8'd2);
    send_word(CMD_CLEAR,  16'h0000, 8'd0);
    drain_replies();

    // Random part: segments of one command mix, bursts with random gaps,
    // and now and then a full drain of the reply side.
    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_WORDS) begin
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(20, 80);
      for (int k = 0; k < seg_len && sent < RANDOM_WORDS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        end
        burst_left--;
        cmd = pick_command(mode);
        // mostly a position inside the list, otherwise any byte
        if (songs_listed > 0 && $urandom_range(0, 99) < 85)
          pos = POS_W'($urandom_range(1, songs_listed));
        else
          pos = POS_W'($urandom_range(0, 255));
        send_word(cmd, 16'($urandom_range(0, 65535)), pos);
        if (cmd <= CMD_UNDO) sent++;
      end
      if ($urandom_range(0, 5) == 0) drain_replies();
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/plhs_pkg.sv
sv/plhs_ram.sv
sv/plhs_ctrl.sv
sv/playlist_with_history_stack.sv
sv/plhs_checker.sv
tb/playlist_checker.sv
tb/tb_playlist_with_history_stack.sv
